### rtl/pip_pkg.sv
// Package with the constants, types and codes shared by the point-in-polygon test.
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;

  // Widths of the fields at the ports.
  localparam int FIELD_W  = 16;
  localparam int VIDX_W   = 6;
  localparam int VCOUNT_W = 7;

  // Coordinates keep at most the field width.
  localparam int CW     = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int VTX_W  = 2 * CW;
  localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = CW + 1;
  localparam int PROD_W = 2 * DIFF_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } vertex_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic             is_query;
    logic             write_ok;
    logic [IDX_W-1:0] addr;
    vertex_t          vtx;
  } item_t;

endpackage
`default_nettype wire

### rtl/point_in_polygon_test.sv
// Top level of the point-in-polygon test by crossing number.
//
// Input channel (in_valid / in_stall) carries one transaction per item:
// opcode 0 loads coord_x, coord_y into store entry vertex_index and gives no
// result; opcode 1 tests the point coord_x, coord_y against the polygon made
// of entries 0 .. n-1, n being vertex_count clamped to MAX_VERTICES, and gives
// one inside_res on the output channel (out_valid / out_stall). cfg_we writes
// cfg_wdata into vertex_count. Items are executed strictly in order through
// a four-entry queue. A load is written into the store as it is popped. A
// query makes n + 1 store reads, one per cycle from the single read port of
// the vertex store, then drains the compare pipeline and gives its result;
// n = 0 skips the reads and goes straight to the result.
// Reset clears vertex_count, the queue and the output register; the vertex
// store is not cleared, so entries must be loaded before a query uses them.
// While out_stall holds the result, the walker waits and the front end keeps
// taking transactions until the queue fills, then raises in_stall.
`timescale 1ns / 1ps
`default_nettype none
module point_in_polygon_test
  import pip_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      opcode,
  input  wire logic        [VIDX_W-1:0]  vertex_index,
  input  wire logic signed [FIELD_W-1:0] coord_x,
  input  wire logic signed [FIELD_W-1:0] coord_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           inside_res,
  input  wire logic                      cfg_we,
  input  wire logic        [VCOUNT_W-1:0] cfg_wdata
);

  logic [VCOUNT_W-1:0] vertex_count;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  item_t               front_item;
  item_t               q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  pip_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .vertex_index(vertex_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .push        (q_push),
    .item        (front_item),
    .q_full      (q_full)
  );

  pip_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(front_item),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  pip_back u_back (
    .clk         (clk),
    .rst         (rst),
    .vertex_count(vertex_count),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .inside_res  (inside_res)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue pushed while full");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("input stalled while queue has room");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

### rtl/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/pip_front.sv
// Front end: accepts input transactions, classifies them and hands them to the queue.
`timescale 1ns / 1ps
`default_nettype none
module pip_front
  import pip_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      opcode,
  input  wire logic        [VIDX_W-1:0]  vertex_index,
  input  wire logic signed [FIELD_W-1:0] coord_x,
  input  wire logic signed [FIELD_W-1:0] coord_y,
  output logic                           push,
  output item_t                          item,
  input  wire logic                      q_full
);

  logic  hold_valid;
  logic  accept;
  item_t classified;

  always_comb begin
    classified.is_query = (opcode_t'(opcode) == OP_QUERY);
    // Loads beyond the store depth are dropped.
    classified.write_ok = !classified.is_query && (32'(vertex_index) < MAX_VERTICES);
    classified.addr     = IDX_W'(vertex_index);
    classified.vtx.x    = coord_x[CW-1:0];
    classified.vtx.y    = coord_y[CW-1:0];
  end

  assign in_stall = hold_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = hold_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= classified;
    end
  end

endmodule
`default_nettype wire

### rtl/pip_queue.sv
// Short FIFO of classified items between the front end and the edge walker.
`timescale 1ns / 1ps
`default_nettype none
module pip_queue
  import pip_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      head,
  output logic       empty
);

  item_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

### rtl/pip_back.sv
// Back end: executes loads into the vertex store and walks the polygon edges for queries.
`timescale 1ns / 1ps
`default_nettype none
module pip_back
  import pip_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [VCOUNT_W-1:0] vertex_count,
  input  wire item_t               head,
  input  wire logic                q_empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     inside_res
);

  back_state_t state, state_next;

  logic             ram_we;
  logic             ram_re;
  logic [VTX_W-1:0] ram_rdata;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_first;
  logic [CNT_W-1:0] rd_left;
  logic [CNT_W-1:0] n;
  logic             start;
  logic             finish;
  logic             out_free;

  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic                 parity;

  vertex_t vtx_a;
  vertex_t prev;
  logic    s1_valid;
  logic    s1_first;

  logic signed [DIFF_W-1:0] py_ay, bx_ax, px_ax, by_ay;
  logic                     cand;

  logic                     s2_valid;
  logic                     s2_cand;
  logic                     s2_dy_pos;
  logic signed [PROD_W-1:0] s2_lhs;
  logic signed [PROD_W-1:0] s2_rhs;
  logic                     crosses;

  assign n = (32'(vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count);
  assign out_free = !out_valid || !out_stall;

  pip_ram #(
    .WIDTH(VTX_W),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head.addr),
    .wdata(head.vtx),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    start      = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (!head.is_query) begin
            ram_we = head.write_ok;
          end else begin
            start = 1'b1;
            if (n == '0) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
        if (!rd_first && rd_left == CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The walk reads the last vertex first, then vertices 0 to n-1, so every
  // read after the first closes one edge with the vertex read before it.
  always_ff @(posedge clk) begin
    if (start) begin
      px       <= head.vtx.x;
      py       <= head.vtx.y;
      rd_addr  <= IDX_W'(n - 1'b1);
      rd_first <= 1'b1;
      rd_left  <= n;
    end else if (ram_re) begin
      if (rd_first) begin
        rd_first <= 1'b0;
        rd_addr  <= '0;
      end else begin
        rd_addr <= rd_addr + 1'b1;
        rd_left <= rd_left - 1'b1;
      end
    end
  end

  assign vtx_a = vertex_t'(ram_rdata);

  always_comb begin
    py_ay = DIFF_W'(py) - DIFF_W'(vtx_a.y);
    bx_ax = DIFF_W'(prev.x) - DIFF_W'(vtx_a.x);
    px_ax = DIFF_W'(px) - DIFF_W'(vtx_a.x);
    by_ay = DIFF_W'(prev.y) - DIFF_W'(vtx_a.y);
    cand  = ((vtx_a.y < py && prev.y >= py) || (prev.y < py && vtx_a.y >= py)) &&
            (vtx_a.x <= px || prev.x <= px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ram_re;
      s2_valid <= s1_valid && !s1_first;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= rd_first;
    if (s1_valid) begin
      prev <= vtx_a;
    end
    s2_cand   <= cand;
    s2_dy_pos <= (prev.y > vtx_a.y);
    s2_lhs    <= PROD_W'(py_ay) * PROD_W'(bx_ax);
    s2_rhs    <= PROD_W'(px_ax) * PROD_W'(by_ay);
  end

  // The sign of dy decides which way the exact cross-multiplied compare goes.
  assign crosses = s2_cand && (s2_dy_pos ? (s2_lhs < s2_rhs) : (s2_lhs > s2_rhs));

  always_ff @(posedge clk) begin
    if (start) begin
      parity <= 1'b0;
    end else if (s2_valid && crosses) begin
      parity <= !parity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      inside_res <= parity;
    end
  end

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the point-in-polygon block with a crossing-parity predictor.
`timescale 1ns / 1ps
module tb_top;
  import pip_pkg::*;

  localparam int HALF_PERIOD   = 1;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int MAX_REPORTS   = 10;

  localparam logic signed [FIELD_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic signed [FIELD_W-1:0] COORD_MAX = 16'sh7fff;

  typedef enum int {
    SCALE_GRID,
    SCALE_MID,
    SCALE_FULL,
    SCALE_BOUNDARY
  } coord_scale_t;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic                      opcode       = OP_LOAD;
  logic        [VIDX_W-1:0]  vertex_index = '0;
  logic signed [FIELD_W-1:0] coord_x      = '0;
  logic signed [FIELD_W-1:0] coord_y      = '0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic                      inside_res;
  logic                      cfg_we       = 1'b0;
  logic        [VCOUNT_W-1:0] cfg_wdata   = '0;

  // Shadow copy of the polygon and the vertex count.
  logic signed [FIELD_W-1:0] shadow_x [MAX_VERTICES];
  logic signed [FIELD_W-1:0] shadow_y [MAX_VERTICES];
  int unsigned               shadow_count = 0;
  logic                      inside_expected [$];

  int error_count   = 0;
  int items_sent    = 0;
  int idle_cycles   = 0;
  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  bit long_hold_req = 1'b0;

  point_in_polygon_test dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .inside_res   (inside_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic predict_inside(input logic signed [FIELD_W-1:0] px_in,
                                          input logic signed [FIELD_W-1:0] py_in);
    longint px, py, ax, ay, bx, by, lhs, rhs;
    int     n, i, j;
    logic   parity;
    px     = px_in;
    py     = py_in;
    parity = 1'b0;
    n      = (shadow_count > MAX_VERTICES) ? MAX_VERTICES : shadow_count;
    j      = n - 1;
    for (i = 0; i < n; i++) begin
      ax = shadow_x[i];
      ay = shadow_y[i];
      bx = shadow_x[j];
      by = shadow_y[j];
      // Half-open straddle of the ray height, and at least one end at or left of the point.
      if (((ay < py && by >= py) || (by < py && ay >= py)) && (ax <= px || bx <= px)) begin
        // The crossing x is compared with px by cross-multiplying; the sign of dy flips it.
        lhs = (py - ay) * (bx - ax);
        rhs = (px - ax) * (by - ay);
        if ((by > ay) ? (lhs < rhs) : (lhs > rhs)) begin
          parity = ~parity;
        end
      end
      j = i;
    end
    return parity;
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_coord(input coord_scale_t scale);
    logic signed [FIELD_W-1:0] boundary_vals [7];
    boundary_vals = '{COORD_MIN, COORD_MIN + 16'sd1, -16'sd1, 16'sd0, 16'sd1,
                      COORD_MAX - 16'sd1, COORD_MAX};
    case (scale)
      SCALE_GRID: return FIELD_W'($urandom_range(0, 16) - 8);
      SCALE_MID:  return FIELD_W'($urandom_range(0, 2000) - 1000);
      SCALE_FULL: return FIELD_W'($urandom());
      default:    return boundary_vals[$urandom_range(0, 6)];
    endcase
  endfunction

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // Offers one transaction and updates the shadow at the edge where it is taken.
  task automatic offer_item(input opcode_t op, input logic [VIDX_W-1:0] idx,
                            input logic signed [FIELD_W-1:0] x,
                            input logic signed [FIELD_W-1:0] y);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    vertex_index <= idx;
    coord_x      <= x;
    coord_y      <= y;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      shadow_x[idx] = x;
      shadow_y[idx] = y;
    end else begin
      inside_expected.push_back(predict_inside(x, y));
    end
    items_sent++;
  endtask

  // Waits until every query has answered and trailing loads have drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (inside_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int unsigned value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= VCOUNT_W'(value);
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_count = value;
  endtask

  task automatic load_polygon(input int used, input coord_scale_t scale);
    int i;
    for (i = 0; i < used; i++) begin
      offer_item(OP_LOAD, VIDX_W'(i), pick_coord(scale), pick_coord(scale));
    end
  endtask

  task automatic random_query(input coord_scale_t scale, input int used);
    logic signed [FIELD_W-1:0] x, y;
    int pick, k;
    pick = $urandom_range(0, 9);
    x    = pick_coord(scale);
    y    = pick_coord(scale);
    if (used > 0 && pick < 5) begin
      // Sitting at a vertex height exercises the half-open rule.
      k = $urandom_range(0, used - 1);
      y = shadow_y[k];
      if (pick < 2) begin
        x = shadow_x[k];
      end
    end else if (pick == 9) begin
      x = pick_coord(SCALE_BOUNDARY);
      y = pick_coord(SCALE_BOUNDARY);
    end
    offer_item(OP_QUERY, VIDX_W'($urandom()), x, y);
  endtask

  task automatic test_empty_polygon();
    // Right after reset the count is zero, so nothing is read from the store.
    offer_item(OP_QUERY, '0, COORD_MIN, COORD_MIN);
    offer_item(OP_QUERY, '1, COORD_MAX, COORD_MAX);
    offer_item(OP_QUERY, '0, 16'sd0, 16'sd0);
    offer_item(OP_LOAD, VIDX_W'(0), -16'sd5, -16'sd5);
    offer_item(OP_LOAD, VIDX_W'(1), 16'sd5, 16'sd5);
    offer_item(OP_LOAD, VIDX_W'(MAX_VERTICES - 1), COORD_MAX, COORD_MIN);
    write_vertex_count(1);
    offer_item(OP_QUERY, '0, 16'sd0, 16'sd0);
    write_vertex_count(2);
    // Both directions of the single segment cross, so the parity stays even.
    offer_item(OP_QUERY, '0, 16'sd10, 16'sd0);
  endtask

  task automatic test_extreme_square();
    offer_item(OP_LOAD, VIDX_W'(0), COORD_MIN, COORD_MIN);
    offer_item(OP_LOAD, VIDX_W'(1), COORD_MAX, COORD_MIN);
    offer_item(OP_LOAD, VIDX_W'(2), COORD_MAX, COORD_MAX);
    offer_item(OP_LOAD, VIDX_W'(3), COORD_MIN, COORD_MAX);
    write_vertex_count(4);
    offer_item(OP_QUERY, '0, 16'sd0, 16'sd0);
    offer_item(OP_QUERY, '0, COORD_MIN, 16'sd0);
    offer_item(OP_QUERY, '0, COORD_MAX, 16'sd0);
    offer_item(OP_QUERY, '0, COORD_MIN, COORD_MIN);
    offer_item(OP_QUERY, '0, COORD_MAX, COORD_MAX);
    offer_item(OP_QUERY, '0, 16'sd0, COORD_MIN);
    offer_item(OP_QUERY, '0, 16'sd0, COORD_MAX);
    offer_item(OP_QUERY, '0, -16'sd1, COORD_MAX - 16'sd1);
    offer_item(OP_QUERY, '0, COORD_MIN + 16'sd1, COORD_MIN + 16'sd1);
  endtask

  task automatic test_count_above_depth();
    // Counts past the store depth are clamped, so every entry must be loaded first.
    write_vertex_count(127);
    load_polygon(MAX_VERTICES, SCALE_MID);
    repeat (4) random_query(SCALE_MID, MAX_VERTICES);
    write_vertex_count(65);
    repeat (2) random_query(SCALE_MID, MAX_VERTICES);
    write_vertex_count(64);
    repeat (2) random_query(SCALE_MID, MAX_VERTICES);
  endtask

  task automatic test_back_pressure();
    write_vertex_count(5);
    load_polygon(5, SCALE_GRID);
    tx_idle_en    = 1'b0;
    long_hold_req = 1'b1;
    repeat (24) random_query(SCALE_GRID, 5);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_polygons();
    int           target, count, used, r;
    coord_scale_t scale;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      r = $urandom_range(0, 19);
      case (r)
        0:       count = 0;
        1:       count = $urandom_range(1, 2);
        2:       count = $urandom_range(MAX_VERTICES + 1, 127);
        3:       count = MAX_VERTICES;
        4, 5, 6: count = $urandom_range(13, MAX_VERTICES - 1);
        default: count = $urandom_range(3, 12);
      endcase
      scale      = coord_scale_t'($urandom_range(0, 3));
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      write_vertex_count(count);
      used = (count > MAX_VERTICES) ? MAX_VERTICES : count;
      load_polygon(used, scale);
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 4) == 0) begin
          offer_item(OP_LOAD, VIDX_W'($urandom()), pick_coord(scale), pick_coord(scale));
        end else begin
          random_query(scale, used);
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_empty_polygon();
    test_extreme_square();
    test_count_above_depth();
    test_back_pressure();
    test_random_polygons();
    settle();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: a short stall per transaction, or one long hold-off when requested.
  initial begin : result_sink
    int hold;
    forever begin
      hold = rx_idle_en ? $urandom_range(0, 3) : 0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (hold > 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (inside_expected.size() == 0) begin
        log_error($sformatf("inside_res %0b arrived with no query outstanding", inside_res));
      end else begin
        want = inside_expected.pop_front();
        if (inside_res !== want) begin
          log_error($sformatf("inside_res expected %0b, got %0b", want, inside_res));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, inside_expected.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
rtl/pip_pkg.sv
rtl/pip_ram.sv
rtl/pip_front.sv
rtl/pip_queue.sv
rtl/pip_back.sv
rtl/point_in_polygon_test.sv
tb/tb_top.sv
